// File: src/dns_message_parser_core_macros.svh
// Assertion helpers for the DNS parser core.
// Both expect clk and arst_n in scope.
`ifndef DNS_MESSAGE_PARSER_CORE_MACROS_SVH
`define DNS_MESSAGE_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DMP_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmp: implication check failed");

// next-cycle implication
`define DMP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmp: next-cycle check failed");

`else

`define DMP_ASSERT_IMPLIES(label, ante, cons)
`define DMP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/dmp_pkg.sv
package dmp_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_NAME   = 2'd2;
	localparam logic [1:0] KIND_DATA   = 2'd3;

	// sections
	localparam logic [1:0] SEC_QUESTION   = 2'd0;
	localparam logic [1:0] SEC_ANSWER     = 2'd1;
	localparam logic [1:0] SEC_AUTHORITY  = 2'd2;
	localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

	// byte positions within fixed fields
	localparam logic [3:0] HDR_ID_BYTES    = 4'd2;   // id occupies bytes 0..1
	localparam logic [3:0] HDR_COUNT_FIRST = 4'd4;   // counts start after the flags word
	localparam logic [3:0] HDR_LAST        = 4'd11;  // 12-byte header
	localparam logic [3:0] QFIX_LAST       = 4'd3;   // type + class
	localparam logic [3:0] RR_NAME_BYTES   = 4'd2;   // fixed 2-byte name
	localparam logic [3:0] RR_LEN_FIRST    = 4'd10;  // data length bytes 10..11
	localparam logic [3:0] RR_LAST         = 4'd11;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_start;
	} byte_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  section;
		logic [15:0] msg_id;
		logic [15:0] question_count;
		logic [15:0] answer_count;
		logic [15:0] authority_count;
		logic [15:0] additional_count;
		logic [15:0] record_type;
		logic [15:0] record_class;
		logic [31:0] time_to_live;
		logic [15:0] field_length;
		logic [7:0]  out_byte;
	} result_t;

endpackage

// File: src/dns_message_parser_core.sv
// DNS message parser: one message byte per word, at most one result per byte.
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the byte side stalls only while a result is held
// by a stalled result side.
// Reset (arst_n low, asynchronous): parser idle awaiting a message start,
// result register empty.
`include "dns_message_parser_core_macros.svh"

module dns_message_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  dmp_pkg::byte_word_t byte_word,
	output logic                result_valid,
	input  logic                result_stall,
	output dmp_pkg::result_t    result_word
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_QNAME,
		PH_QFIXED,
		PH_RFIXED,
		PH_RDATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic        found;
		logic [1:0]  sec;
		logic [15:0] cnt;
	} pick_t;

	// first non-empty section at or after 'from'
	function automatic pick_t pick_section(logic [2:0] from, logic [15:0] qd,
			logic [47:0] cnts);
		pick_t       r;
		logic [15:0] c;
		logic [63:0] all_cnts;
		r        = '0;
		all_cnts = {qd, cnts};
		for (int s = 3; s >= 0; s--) begin
			c = all_cnts[16*(3-s) +: 16];
			if (s >= int'(from) && c != 16'd0) begin
				r.found = 1'b1;
				r.sec   = 2'(s);
				r.cnt   = c;
			end
		end
		return r;
	endfunction

	phase_t      phase_q, phase_n, ph;
	logic [3:0]  idx_q, idx_n, ix;
	logic [15:0] hid_q, hid_n;
	logic [63:0] hsh_q, hsh_n;
	logic [15:0] recs_q, recs_n;
	logic [1:0]  sect_q, sect_n;
	logic [47:0] saved_q, saved_n;
	logic [63:0] rsh_q, rsh_n;
	logic [15:0] nlen_q, nlen_n;
	logic [15:0] dleft_q, dleft_n;

	logic             fire;
	logic [7:0]       b;
	logic             res_v;
	dmp_pkg::result_t res;
	logic             do_finish, do_enter, do_start;
	logic [2:0]       en_from;
	logic [15:0]      en_qd;
	logic [47:0]      en_cnts;
	logic [1:0]       start_sec;
	pick_t            sel;

	assign byte_stall = result_valid & result_stall;
	assign fire       = byte_valid & ~byte_stall;
	assign b          = byte_word.in_byte;

	always_comb begin
		ph        = byte_word.msg_start ? PH_HEADER : phase_q;
		ix        = byte_word.msg_start ? 4'd0 : idx_q;
		phase_n   = ph;
		idx_n     = ix;
		hid_n     = hid_q;
		hsh_n     = hsh_q;
		recs_n    = recs_q;
		sect_n    = sect_q;
		saved_n   = saved_q;
		rsh_n     = rsh_q;
		nlen_n    = nlen_q;
		dleft_n   = dleft_q;
		res_v     = 1'b0;
		res       = '0;
		do_finish = 1'b0;
		do_enter  = 1'b0;
		do_start  = 1'b0;
		en_from   = 3'd0;
		en_qd     = 16'd0;
		en_cnts   = saved_q;
		start_sec = sect_q;
		sel       = '0;

		case (ph)
			PH_HEADER: begin
				if (ix < dmp_pkg::HDR_ID_BYTES) begin
					hid_n = {hid_q[7:0], b};
				end else if (ix >= dmp_pkg::HDR_COUNT_FIRST) begin
					hsh_n = {hsh_q[55:0], b};
				end
				idx_n = ix + 4'd1;
				if (ix >= dmp_pkg::HDR_LAST) begin
					res_v                = 1'b1;
					res.kind             = dmp_pkg::KIND_HEADER;
					res.msg_id           = hid_n;
					res.question_count   = hsh_n[63:48];
					res.answer_count     = hsh_n[47:32];
					res.authority_count  = hsh_n[31:16];
					res.additional_count = hsh_n[15:0];
					saved_n              = hsh_n[47:0];
					do_enter             = 1'b1;
					en_from              = 3'd0;
					en_qd                = hsh_n[63:48];
					en_cnts              = hsh_n[47:0];
				end
			end
			PH_QNAME: begin
				if (nlen_q != 16'hFFFF) begin
					nlen_n = nlen_q + 16'd1;
				end
				res_v        = 1'b1;
				res.kind     = dmp_pkg::KIND_NAME;
				res.section  = sect_q;
				res.out_byte = b;
				if (b == 8'd0) begin
					phase_n = PH_QFIXED;
					idx_n   = 4'd0;
					rsh_n   = '0;
				end
			end
			PH_QFIXED: begin
				rsh_n = {32'd0, rsh_q[23:0], b};
				idx_n = ix + 4'd1;
				if (ix >= dmp_pkg::QFIX_LAST) begin
					res_v            = 1'b1;
					res.kind         = dmp_pkg::KIND_RECORD;
					res.section      = sect_q;
					res.record_type  = rsh_n[31:16];
					res.record_class = rsh_n[15:0];
					res.field_length = nlen_q;
					do_finish        = 1'b1;
				end
			end
			PH_RFIXED: begin
				idx_n = ix + 4'd1;
				if (ix < dmp_pkg::RR_NAME_BYTES) begin
					res_v        = 1'b1;
					res.kind     = dmp_pkg::KIND_NAME;
					res.section  = sect_q;
					res.out_byte = b;
				end else if (ix < dmp_pkg::RR_LEN_FIRST) begin
					rsh_n = {rsh_q[55:0], b};
				end else begin
					dleft_n = {dleft_q[7:0], b};
					if (ix >= dmp_pkg::RR_LAST) begin
						res_v            = 1'b1;
						res.kind         = dmp_pkg::KIND_RECORD;
						res.section      = sect_q;
						res.record_type  = rsh_q[63:48];
						res.record_class = rsh_q[47:32];
						res.time_to_live = rsh_q[31:0];
						res.field_length = dleft_n;
						if (dleft_n == 16'd0) begin
							do_finish = 1'b1;
						end else begin
							phase_n = PH_RDATA;
							idx_n   = 4'd0;
						end
					end
				end
			end
			PH_RDATA: begin
				res_v        = 1'b1;
				res.kind     = dmp_pkg::KIND_DATA;
				res.section  = sect_q;
				res.out_byte = b;
				if (dleft_q != 16'd0) begin
					dleft_n = dleft_q - 16'd1;
				end
				if (dleft_n == 16'd0) begin
					do_finish = 1'b1;
				end
			end
			default: begin
				// idle or done: byte is dropped
			end
		endcase

		if (do_finish) begin
			recs_n = recs_q - 16'd1;
			if (recs_n != 16'd0) begin
				do_start = 1'b1;
			end else begin
				do_enter = 1'b1;
				en_from  = {1'b0, sect_q} + 3'd1;
				en_qd    = 16'd0;
				en_cnts  = saved_q;
			end
		end

		if (do_enter) begin
			sel = pick_section(en_from, en_qd, en_cnts);
			if (sel.found) begin
				sect_n    = sel.sec;
				recs_n    = sel.cnt;
				start_sec = sel.sec;
				do_start  = 1'b1;
			end else begin
				phase_n = PH_DONE;
				idx_n   = 4'd0;
			end
		end

		if (do_start) begin
			phase_n = (start_sec == dmp_pkg::SEC_QUESTION) ? PH_QNAME : PH_RFIXED;
			idx_n   = 4'd0;
			rsh_n   = '0;
			nlen_n  = 16'd0;
			dleft_n = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= 4'd0;
			hid_q        <= 16'd0;
			hsh_q        <= '0;
			recs_q       <= 16'd0;
			sect_q       <= dmp_pkg::SEC_QUESTION;
			saved_q      <= '0;
			rsh_q        <= '0;
			nlen_q       <= 16'd0;
			dleft_q      <= 16'd0;
			result_valid <= 1'b0;
		end else begin
			if (fire) begin
				phase_q      <= phase_n;
				idx_q        <= idx_n;
				hid_q        <= hid_n;
				hsh_q        <= hsh_n;
				recs_q       <= recs_n;
				sect_q       <= sect_n;
				saved_q      <= saved_n;
				rsh_q        <= rsh_n;
				nlen_q       <= nlen_n;
				dleft_q      <= dleft_n;
				result_valid <= res_v;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded only with the byte that produces it
	always_ff @(posedge clk) begin
		if (fire && res_v) begin
			result_word <= res;
		end
	end

	`DMP_ASSERT_NEXT(a_start_enters_header, fire && byte_word.msg_start, phase_q == PH_HEADER)
	`DMP_ASSERT_IMPLIES(a_header_no_section,
		result_valid && result_word.kind == dmp_pkg::KIND_HEADER,
		result_word.section == dmp_pkg::SEC_QUESTION && result_word.record_type == 16'd0)
	`DMP_ASSERT_IMPLIES(a_record_pending,
		phase_q == PH_QNAME || phase_q == PH_QFIXED || phase_q == PH_RFIXED
		|| phase_q == PH_RDATA, recs_q != 16'd0)
	`DMP_ASSERT_IMPLIES(a_data_left, phase_q == PH_RDATA, dleft_q != 16'd0)

endmodule
